@@ rtl/core/fpa_pkg.sv @@
// Package for the Q24.8 fixed-point ALU core: codes, derived widths, stage types
// and the saturation and divider step functions.
// No dependencies; used by fpa_div and fixed_point_alu_q24_8_core.
package fpa_pkg;

   // Number format
   localparam int FRAC_BITS = 8;
   localparam int SCALE_M1  = (2 ** FRAC_BITS) - 1;

   // Divider geometry: quotient bits, bits resolved per stage, stage count
   localparam int QW  = 32 + FRAC_BITS;
   localparam int BPS = 4;
   localparam int DS  = (QW + BPS - 1) / BPS;
   localparam int DW  = DS * BPS;

   // Commands
   localparam logic [3:0] CMD_ADD        = 4'd0;
   localparam logic [3:0] CMD_SUB        = 4'd1;
   localparam logic [3:0] CMD_MUL        = 4'd2;
   localparam logic [3:0] CMD_DIV        = 4'd3;
   localparam logic [3:0] CMD_COMPARE    = 4'd4;
   localparam logic [3:0] CMD_MIN        = 4'd5;
   localparam logic [3:0] CMD_MAX        = 4'd6;
   localparam logic [3:0] CMD_INC        = 4'd7;
   localparam logic [3:0] CMD_DEC        = 4'd8;
   localparam logic [3:0] CMD_FROM_INT   = 4'd9;
   localparam logic [3:0] CMD_FROM_FLOAT = 4'd10;
   localparam logic [3:0] CMD_TO_INT     = 4'd11;
   localparam logic [3:0] CMD_TO_FLOAT   = 4'd12;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;
   localparam logic [1:0] ST_NAN  = 2'd3;

   localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] VAL_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } res_type;

   // Second stage: flags, early result and operands for the slower paths
   typedef struct packed {
      logic [3:0]  cmd;
      logic        lt;
      logic        eq;
      logic        gt;
      res_type     early;
      logic [63:0] wide;
      logic [4:0]  lead;
      logic        sgn;
      logic        fok;
   } stage2_type;

   // Finished non-divide result travelling alongside the divider
   typedef struct packed {
      logic [3:0] cmd;
      logic       lt;
      logic       eq;
      logic       gt;
      res_type    res;
   } fast_type;

   typedef struct packed {
      logic [32:0]   rem;
      logic [DW-1:0] quo;
   } div_type;

   // Clamp a signed 64-bit value into 32 bits, flagging overflow
   function automatic res_type sat64(input logic signed [63:0] v);
      res_type r;
      r.status = ST_OK;
      r.value  = v[31:0];
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r.value  = VAL_MAX;
         r.status = ST_OVF;
      end else if (v < 64'shFFFF_FFFF_8000_0000) begin
         r.value  = VAL_MIN;
         r.status = ST_OVF;
      end
      return r;
   endfunction

   // BPS restoring division steps; quotient bits shift in at the bottom
   function automatic div_type div_steps(input logic [32:0] rem, input logic [DW-1:0] quo,
                                         input logic [31:0] dvs);
      div_type d;
      d.rem = rem;
      d.quo = quo;
      for (int j = 0; j < BPS; j++) begin
         d.rem = {d.rem[31:0], d.quo[DW-1]};
         d.quo = {d.quo[DW-2:0], 1'b0};
         if (d.rem >= {1'b0, dvs}) begin
            d.rem    = d.rem - {1'b0, dvs};
            d.quo[0] = 1'b1;
         end
      end
      return d;
   endfunction

endpackage

@@ rtl/core/fixed_point_alu_q24_8_core.sv @@
// Q24.8 fixed-point ALU core: the path from acceptance to result is set by the
// DS-stage divider pipeline.
// One transaction per cycle unless stalled; every command takes the same path length.
// The whole pipeline stalls only while a finished result waits on rsp_tready.
// Synchronous active-high reset clears the valid bits; payload is not reset.
// Depends on fpa_pkg and fpa_div.
module fixed_point_alu_q24_8_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // operand_a[31:0], operand_b[63:32]
   input  logic [3:0]  req_tuser,  // command[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // result_value[31:0], less_flag[32], equal_flag[33],
                                   // greater_flag[34], status[36:35], zero[39:37]
);

   localparam int VN = fpa_pkg::DS + 2;

   logic                   en;
   logic                   vld_ff [VN];
   logic                   rsp_vld_ff;
   logic [3:0]             cmd1_ff;
   logic signed [31:0]     a1_ff;
   logic signed [31:0]     b1_ff;
   fpa_pkg::stage2_type    st2_in, st2_ff;
   logic [fpa_pkg::DW-1:0] dvd2_in, dvd2_ff;
   logic [31:0]            dvs2_in, dvs2_ff;
   logic                   neg2_in, neg2_ff;
   fpa_pkg::fast_type      fast_in;
   fpa_pkg::fast_type      fast_ff [fpa_pkg::DS];
   logic [fpa_pkg::DW-1:0] quo;
   logic                   quo_neg;
   fpa_pkg::fast_type      rsp_in, rsp_ff;

   // global advance: the pipe moves unless a result is held
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < VN; k++) vld_ff[k] <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < VN; k++) vld_ff[k] <= vld_ff[k-1];
         rsp_vld_ff <= vld_ff[VN-1];
      end
   end

   // stage 1: capture
   always_ff @(posedge clock) begin
      if (en) begin
         cmd1_ff <= req_tuser;
         a1_ff   <= req_tdata[31:0];
         b1_ff   <= req_tdata[63:32];
      end
   end

   // stage 2: flags, simple commands, multiply, float decode, leading one
   always_comb begin
      logic [31:0]        amag;
      logic [31:0]        bmag;
      logic signed [31:0] tadj;
      logic [7:0]         e8;
      logic [23:0]        m24;
      logic signed [9:0]  shv;
      logic signed [9:0]  nv;
      logic [23:0]        rnd;
      st2_in        = '0;
      st2_in.cmd    = cmd1_ff;
      st2_in.lt     = a1_ff < b1_ff;
      st2_in.eq     = a1_ff == b1_ff;
      st2_in.gt     = a1_ff > b1_ff;
      st2_in.early  = '{value: 32'd0, status: fpa_pkg::ST_OK};
      amag          = a1_ff[31] ? 32'(-a1_ff) : a1_ff;
      bmag          = b1_ff[31] ? 32'(-b1_ff) : b1_ff;
      tadj          = a1_ff + (a1_ff[31] ? 32'sd0 + 32'(fpa_pkg::SCALE_M1) : 32'sd0);
      e8            = a1_ff[30:23];
      m24           = (e8 == 8'd0) ? {1'b0, a1_ff[22:0]} : {1'b1, a1_ff[22:0]};
      shv           = $signed({2'b00, ((e8 == 8'd0) ? 8'd1 : e8)}) - 10'sd150
                      + $signed(10'(fpa_pkg::FRAC_BITS));
      nv            = -shv;
      rnd           = (m24 >> nv[4:0]) + ((m24 >> (nv[4:0] - 5'd1)) & 24'd1);
      case (cmd1_ff)
         fpa_pkg::CMD_ADD:  st2_in.early = fpa_pkg::sat64(64'(a1_ff) + 64'(b1_ff));
         fpa_pkg::CMD_SUB:  st2_in.early = fpa_pkg::sat64(64'(a1_ff) - 64'(b1_ff));
         fpa_pkg::CMD_MUL:  st2_in.wide  = a1_ff * b1_ff;
         fpa_pkg::CMD_DIV: begin
            if (b1_ff == 32'sd0) st2_in.early.status = fpa_pkg::ST_DIV0;
         end
         fpa_pkg::CMD_MIN:  st2_in.early.value = st2_in.lt ? a1_ff : b1_ff;
         fpa_pkg::CMD_MAX:  st2_in.early.value = st2_in.gt ? a1_ff : b1_ff;
         fpa_pkg::CMD_INC:  st2_in.early = fpa_pkg::sat64(64'(a1_ff) + 64'sd1);
         fpa_pkg::CMD_DEC:  st2_in.early = fpa_pkg::sat64(64'(a1_ff) - 64'sd1);
         fpa_pkg::CMD_FROM_INT:
            st2_in.early = fpa_pkg::sat64(64'(a1_ff) <<< fpa_pkg::FRAC_BITS);
         fpa_pkg::CMD_TO_INT: st2_in.early.value = tadj >>> fpa_pkg::FRAC_BITS;
         fpa_pkg::CMD_FROM_FLOAT: begin
            st2_in.sgn = a1_ff[31];
            if (e8 == 8'hFF) begin
               // infinity saturates, NaN reports
               if (a1_ff[22:0] != 23'd0) begin
                  st2_in.early.status = fpa_pkg::ST_NAN;
               end else begin
                  st2_in.early.value  = a1_ff[31] ? fpa_pkg::VAL_MIN : fpa_pkg::VAL_MAX;
                  st2_in.early.status = fpa_pkg::ST_OVF;
               end
            end else if (m24 != 24'd0) begin
               if (shv >= 10'sd0) begin
                  if (shv > 10'sd39) begin
                     st2_in.early.value  = a1_ff[31] ? fpa_pkg::VAL_MIN : fpa_pkg::VAL_MAX;
                     st2_in.early.status = fpa_pkg::ST_OVF;
                  end else begin
                     st2_in.wide = 64'(m24) << shv[5:0];
                     st2_in.fok  = 1'b1;
                  end
               end else if (nv <= 10'sd25) begin
                  st2_in.wide = 64'(rnd);
                  st2_in.fok  = 1'b1;
               end
            end
         end
         fpa_pkg::CMD_TO_FLOAT: begin
            st2_in.sgn  = a1_ff[31];
            st2_in.wide = 64'(amag);
            for (int i = 0; i < 32; i++) begin
               if (amag[i]) st2_in.lead = 5'(i);
            end
         end
         default: ;
      endcase
      // divider operands
      dvd2_in = fpa_pkg::DW'(amag) << fpa_pkg::FRAC_BITS;
      dvs2_in = bmag;
      neg2_in = a1_ff[31] ^ b1_ff[31];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st2_ff  <= st2_in;
         dvd2_ff <= dvd2_in;
         dvs2_ff <= dvs2_in;
         neg2_ff <= neg2_in;
      end
   end

   // stage 3: multiply scaling, float saturation, float packing
   always_comb begin
      logic signed [63:0] padj;
      logic [31:0]        norm;
      logic [23:0]        mant;
      logic               rup;
      logic [24:0]        m25;
      logic [8:0]         pe;
      fast_in.cmd = st2_ff.cmd;
      fast_in.lt  = st2_ff.lt;
      fast_in.eq  = st2_ff.eq;
      fast_in.gt  = st2_ff.gt;
      fast_in.res = st2_ff.early;
      padj = $signed(st2_ff.wide) + (st2_ff.wide[63] ? 64'(fpa_pkg::SCALE_M1) : 64'sd0);
      norm = st2_ff.wide[31:0] << (5'd31 - st2_ff.lead);
      mant = norm[31:8];
      rup  = norm[7] && ((|norm[6:0]) || mant[0]);
      m25  = {1'b0, mant} + 25'(rup);
      pe   = 9'(st2_ff.lead) + 9'(m25[24]) + 9'd127 - 9'(fpa_pkg::FRAC_BITS);
      case (st2_ff.cmd)
         fpa_pkg::CMD_MUL: fast_in.res = fpa_pkg::sat64(padj >>> fpa_pkg::FRAC_BITS);
         fpa_pkg::CMD_FROM_FLOAT: begin
            if (st2_ff.fok) begin
               fast_in.res = fpa_pkg::sat64(st2_ff.sgn ? -$signed(st2_ff.wide)
                                                       : $signed(st2_ff.wide));
            end
         end
         fpa_pkg::CMD_TO_FLOAT: begin
            if (st2_ff.wide[31:0] != 32'd0) begin
               fast_in.res.value = {st2_ff.sgn, pe[7:0],
                                    (m25[24] ? 23'd0 : m25[22:0])};
            end
         end
         default: ;
      endcase
   end

   // delay line that keeps step with the divider
   always_ff @(posedge clock) begin
      if (en) begin
         fast_ff[0] <= fast_in;
         for (int k = 1; k < fpa_pkg::DS; k++) fast_ff[k] <= fast_ff[k-1];
      end
   end

   fpa_div u_div (
      .clock    (clock),
      .enable   (en),
      .dividend (dvd2_ff),
      .divisor  (dvs2_ff),
      .negative (neg2_ff),
      .quotient (quo),
      .quot_neg (quo_neg)
   );

   // final stage: sign and clamp the quotient, select the result
   always_comb begin
      logic over_pos;
      logic over_neg;
      rsp_in   = fast_ff[fpa_pkg::DS-1];
      over_pos = (|quo[fpa_pkg::DW-1:31]);
      over_neg = (|quo[fpa_pkg::DW-1:32]) || (quo[31] && (|quo[30:0]));
      if (rsp_in.cmd == fpa_pkg::CMD_DIV && rsp_in.res.status != fpa_pkg::ST_DIV0) begin
         if (quo_neg) begin
            rsp_in.res.value  = over_neg ? fpa_pkg::VAL_MIN : 32'(-quo[31:0]);
            rsp_in.res.status = over_neg ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
         end else begin
            rsp_in.res.value  = over_pos ? fpa_pkg::VAL_MAX : quo[31:0];
            rsp_in.res.status = over_pos ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {3'd0, rsp_ff.res.status, rsp_ff.gt, rsp_ff.eq, rsp_ff.lt,
                        rsp_ff.res.value};

   // checks
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot({rsp_ff.lt, rsp_ff.eq, rsp_ff.gt}))
      else $error("comparison flags not exclusive");

   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.res.status == fpa_pkg::ST_DIV0) |-> rsp_ff.res.value == 32'd0)
      else $error("divide by zero returned nonzero value");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted transaction missing from first stage");

endmodule

@@ rtl/core/fpa_div.sv @@
// Pipelined unsigned restoring divider, BPS quotient bits per stage, DS stages.
// Depends on fpa_pkg.
module fpa_div (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [fpa_pkg::DW-1:0] dividend,
   input  logic [31:0]           divisor,
   input  logic                  negative,
   output logic [fpa_pkg::DW-1:0] quotient,
   output logic                  quot_neg
);

   logic [32:0]            rem_ff [fpa_pkg::DS-1];
   logic [31:0]            dvs_ff [fpa_pkg::DS-1];
   logic [fpa_pkg::DW-1:0] quo_ff [fpa_pkg::DS];
   logic                   neg_ff [fpa_pkg::DS];

   for (genvar k = 0; k < fpa_pkg::DS; k++) begin : g_stage
      logic [32:0]            r_in;
      logic [fpa_pkg::DW-1:0] q_in;
      logic [31:0]            d_in;
      logic                   n_in;
      fpa_pkg::div_type       step_in;

      if (k == 0) begin : g_first
         assign r_in = '0;
         assign q_in = dividend;
         assign d_in = divisor;
         assign n_in = negative;
      end else begin : g_next
         assign r_in = rem_ff[k-1];
         assign q_in = quo_ff[k-1];
         assign d_in = dvs_ff[k-1];
         assign n_in = neg_ff[k-1];
      end

      // one group of division steps
      assign step_in = fpa_pkg::div_steps(r_in, q_in, d_in);

      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k] <= step_in.quo;
            neg_ff[k] <= n_in;
         end
      end

      // remainder and divisor are not needed past the last stage
      if (k < fpa_pkg::DS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= step_in.rem;
               dvs_ff[k] <= d_in;
            end
         end
      end
   end

   assign quotient = quo_ff[fpa_pkg::DS-1];
   assign quot_neg = neg_ff[fpa_pkg::DS-1];

endmodule
